// ----- src/ucd_pkg.sv -----
`default_nettype none

package ucd_pkg;

    // Fixed code points.
    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;

    // Lead byte limits and special leads.
    localparam logic [7:0] LEAD_MIN_TWO   = 8'hC2;
    localparam logic [7:0] LEAD_E0        = 8'hE0;
    localparam logic [7:0] LEAD_ED        = 8'hED;
    localparam logic [7:0] LEAD_F0        = 8'hF0;
    localparam logic [7:0] LEAD_F4        = 8'hF4;
    localparam logic [7:0] FOLLOW_MIN_E0  = 8'hA0;
    localparam logic [7:0] FOLLOW_MIN_F0  = 8'h90;
    localparam logic [7:0] FOLLOW_MAX_F4  = 8'h8F;

    // Sequence length codes.
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_ONE   = 3'd1;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } ucd_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic go;
        logic from_queue;
        logic last;
    } ucd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic replay_more;
    } ucd_status_t;

    // Sequence length announced by a lead byte; zero for a byte that cannot lead.
    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if (c < 8'h80) begin
            len = LEN_ONE;
        end else if (c < 8'hC0) begin
            len = LEN_NONE;
        end else if (c < 8'hE0) begin
            len = LEN_TWO;
        end else if (c < 8'hF0) begin
            len = LEN_THREE;
        end else if (c <= LEAD_F4) begin
            len = LEN_FOUR;
        end else begin
            len = LEN_NONE;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

// ----- src/ucd_ctrl.sv -----
`default_nettype none

module ucd_ctrl
    import ucd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_last,
    output logic             in_ready,
    input  wire ucd_status_t status,
    output ucd_cmd_t         cmd
);

    ucd_state_t state_reg;
    ucd_state_t state_next;
    logic       last_reg;
    logic       last_next;

    // State and the end-of-string flag of the beat being worked off.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    // Next state: stay in replay while the datapath still holds bytes to decode again.
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        if (cmd.go)
        begin
            state_next = status.replay_more ? ST_REPLAY : ST_IDLE;
            if (state_reg == ST_IDLE)
            begin
                last_next = in_last;
            end
        end
    end

    // Outputs: in idle the incoming beat is decoded at once; in replay the queue head is.
    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = status.slot_free;
                cmd.go         = in_valid && status.slot_free;
                cmd.from_queue = 1'b0;
                cmd.last       = in_last;
            end
            ST_REPLAY:
            begin
                in_ready       = 1'b0;
                cmd.go         = status.slot_free;
                cmd.from_queue = 1'b1;
                cmd.last       = last_reg;
            end
            default:
            begin
                in_ready       = 1'b0;
                cmd.go         = 1'b0;
                cmd.from_queue = 1'b0;
                cmd.last       = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/ucd_datapath.sv -----
`default_nettype none

module ucd_datapath
    import ucd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ucd_cmd_t    cmd,
    output ucd_status_t      status,
    input  wire logic [7:0]  in_byte,
    output logic [20:0]      code_point,
    output logic             malformed,
    output logic             cut_short,
    output logic             out_last,
    output logic             out_valid,
    input  wire logic        out_ready
);

    // Sequence state.
    logic [7:0]  lead_reg;
    logic [7:0]  lead_next;
    logic [2:0]  seq_len_reg;
    logic [2:0]  seq_len_next;
    logic [1:0]  fcount_reg;
    logic [1:0]  fcount_next;
    logic [7:0]  fol_reg [3];
    logic [7:0]  fol_new [3];

    // Replay queue.
    logic [7:0]  q_reg [3];
    logic [7:0]  q_next [3];
    logic [1:0]  qlen_reg;
    logic [1:0]  qlen_next;

    // Output register.
    logic [20:0] cp_reg;
    logic        bad_reg;
    logic        cut_reg;
    logic        last_out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;

    // Step results.
    logic [7:0]  cur_byte;
    logic [7:0]  rest [2];
    logic [1:0]  rest_len;
    logic [2:0]  cnt1;
    logic        window_full;
    logic        win_ok;
    logic [20:0] win_cp;
    logic [20:0] v4;
    logic        f1;
    logic        f2;
    logic        f3;
    logic        fail;
    logic        emit;
    logic [20:0] e_cp;
    logic        e_bad;
    logic        e_cut;
    logic        final_beat;
    logic [2:0]  nq_len;

    // Byte under work and what remains of the queue behind it.
    always_comb
    begin
        cur_byte = cmd.from_queue ? q_reg[0] : in_byte;
        rest[0]  = q_reg[1];
        rest[1]  = q_reg[2];
        rest_len = cmd.from_queue ? qlen_reg - 2'd1 : 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            fol_new[i] = (fcount_reg == i[1:0]) ? cur_byte : fol_reg[i];
        end
        cnt1        = {1'b0, fcount_reg} + 3'd1;
        window_full = (seq_len_reg != LEN_NONE) && (cnt1 >= seq_len_reg - 3'd1);
    end

    // Window check on the lead and the followers including the current byte.
    always_comb
    begin
        f1 = fol_new[0][7:6] == 2'b10;
        f2 = fol_new[1][7:6] == 2'b10;
        f3 = fol_new[2][7:6] == 2'b10;
        v4 = {lead_reg[2:0], fol_new[0][5:0], fol_new[1][5:0], fol_new[2][5:0]};
        unique case (seq_len_reg)
            LEN_TWO:
            begin
                win_ok = f1 && (lead_reg >= LEAD_MIN_TWO);
                win_cp = {10'd0, lead_reg[4:0], fol_new[0][5:0]};
            end
            LEN_THREE:
            begin
                win_ok = f1 && f2
                      && !(lead_reg == LEAD_E0 && fol_new[0] < FOLLOW_MIN_E0)
                      && !(lead_reg == LEAD_ED && fol_new[0] >= FOLLOW_MIN_E0);
                win_cp = {5'd0, lead_reg[3:0], fol_new[0][5:0], fol_new[1][5:0]};
            end
            LEN_FOUR:
            begin
                win_ok = f1 && f2 && f3
                      && !(lead_reg == LEAD_F0 && fol_new[0] < FOLLOW_MIN_F0)
                      && !(lead_reg == LEAD_F4 && fol_new[0] > FOLLOW_MAX_F4)
                      && (v4 <= MAX_CP);
                win_cp = v4;
            end
            default:
            begin
                win_ok = 1'b0;
                win_cp = REPL_CHAR;
            end
        endcase
    end

    // One decoding step for the current byte.
    always_comb
    begin
        status.slot_free = !out_valid_reg || out_ready;
        emit         = 1'b0;
        e_cp         = REPL_CHAR;
        e_bad        = 1'b0;
        e_cut        = 1'b0;
        fail         = 1'b0;
        lead_next    = lead_reg;
        seq_len_next = seq_len_reg;
        fcount_next  = fcount_reg;
        if (seq_len_reg == LEN_NONE)
        begin
            unique case (lead_length(cur_byte))
                LEN_ONE:
                begin
                    emit = 1'b1;
                    e_cp = {13'd0, cur_byte};
                end
                LEN_NONE:
                begin
                    emit  = 1'b1;
                    e_bad = 1'b1;
                end
                default:
                begin
                    lead_next    = cur_byte;
                    seq_len_next = lead_length(cur_byte);
                    fcount_next  = 2'd0;
                end
            endcase
        end
        else if (window_full)
        begin
            emit         = 1'b1;
            e_cp         = win_ok ? win_cp : REPL_CHAR;
            e_bad        = !win_ok;
            fail         = !win_ok;
            seq_len_next = LEN_NONE;
            fcount_next  = 2'd0;
        end
        else
        begin
            fcount_next = cnt1[1:0];
        end

        // Followers of a refused window go back in front of the queue.
        nq_len = {1'b0, rest_len} + (fail ? cnt1 : 3'd0);
        case (fail ? cnt1[1:0] : 2'd0)
            2'd1:
            begin
                q_next[0] = fol_new[0];
                q_next[1] = rest[0];
                q_next[2] = rest[1];
            end
            2'd2:
            begin
                q_next[0] = fol_new[0];
                q_next[1] = fol_new[1];
                q_next[2] = rest[0];
            end
            2'd3:
            begin
                q_next[0] = fol_new[0];
                q_next[1] = fol_new[1];
                q_next[2] = fol_new[2];
            end
            default:
            begin
                q_next[0] = rest[0];
                q_next[1] = rest[1];
                q_next[2] = q_reg[2];
            end
        endcase
        qlen_next          = nq_len[1:0];
        status.replay_more = nq_len != 3'd0;

        // The last byte of a string closes it, with a cut-short replacement if a
        // sequence is still open.
        final_beat = cmd.last && (nq_len == 3'd0);
        if (final_beat)
        begin
            if (!emit)
            begin
                emit  = 1'b1;
                e_cp  = REPL_CHAR;
                e_bad = 1'b1;
                e_cut = 1'b1;
            end
            seq_len_next = LEN_NONE;
            fcount_next  = 2'd0;
        end

        if (cmd.go && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg   <= LEN_NONE;
            fcount_reg    <= 2'd0;
            qlen_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.go)
            begin
                seq_len_reg <= seq_len_next;
                fcount_reg  <= fcount_next;
                qlen_reg    <= qlen_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            lead_reg <= lead_next;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i] <= q_next[i];
            end
            if (seq_len_reg != LEN_NONE)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    fol_reg[i] <= fol_new[i];
                end
            end
            if (emit)
            begin
                cp_reg       <= e_cp;
                bad_reg      <= e_bad;
                cut_reg      <= e_cut;
                last_out_reg <= final_beat;
            end
        end
    end

    assign code_point = cp_reg;
    assign malformed  = bad_reg;
    assign cut_short  = cut_reg;
    assign out_last   = last_out_reg;
    assign out_valid  = out_valid_reg;

endmodule

`default_nettype wire

// ----- src/utf8_to_codepoint_decoder_top.sv -----
// UTF-8 to code point decoder.
// Input channel: one string byte per beat on in_byte, with in_last high on the
// final byte of the string; valid/ready handshake.
// Output channel: one code point per beat on code_point, with malformed,
// cut_short and out_last; valid/ready handshake behind an output register.
// A result is registered and shown in the cycle after the byte that completes it.
// Throughput: one byte per cycle while sequences are well formed and the
// output slot is free. A refused multibyte window sends its follower bytes
// (up to three) back through the replay queue in the datapath, worked off
// one byte a cycle with in_ready low while the output slot is free; a
// replayed byte may close another refused window, and the input waits until
// the queue is empty. A string that ends inside a sequence gives one extra
// replacement beat with its last decoded byte, flagged cut_short, and
// out_last marks the last result of every string.
// Reset clears the open sequence, the replay queue and the output valid flag.
// While the receiver holds out_ready low, the shown result stays put and no
// further byte is decoded or accepted.
`default_nettype none

module utf8_to_codepoint_decoder_top
    import ucd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  in_byte,
    input  wire logic        in_last,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic [20:0]      code_point,
    output logic             malformed,
    output logic             cut_short,
    output logic             out_last,
    output logic             out_valid,
    input  wire logic        out_ready
);

    ucd_cmd_t    cmd;
    ucd_status_t status;

    // Sequencing of incoming and replayed bytes.
    ucd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_last),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Sequence state, window check, replay queue and output register.
    ucd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_byte    (in_byte),
        .code_point (code_point),
        .malformed  (malformed),
        .cut_short  (cut_short),
        .out_last   (out_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

`default_nettype wire

// ----- src/ucd_checker.sv -----
`default_nettype none

module ucd_checker
    import ucd_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic [20:0] code_point,
    input wire logic        malformed,
    input wire logic        cut_short,
    input wire logic        out_last,
    input wire logic        out_valid,
    input wire logic        out_ready
);

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(malformed) && $stable(out_last))
        else $error("stalled result beat changed");

    // A good result is a Unicode scalar: in range and no surrogate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !malformed |-> code_point <= MAX_CP
            && code_point[20:11] != 10'b0000011011)
        else $error("decoded value is not a scalar");

    // Every replacement carries the replacement character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && malformed |-> code_point == REPL_CHAR)
        else $error("malformed beat without replacement character");

    // A cut-short beat is a malformed beat that closes the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cut_short |-> malformed && out_last)
        else $error("cut-short beat is not the closing replacement");

endmodule

bind utf8_to_codepoint_decoder_top ucd_checker u_ucd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .code_point (code_point),
    .malformed  (malformed),
    .cut_short  (cut_short),
    .out_last   (out_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ucd_pkg::*;

    localparam int ITEMS        = 420;
    localparam int MAX_RESULTS  = 4;
    localparam int HOLD_CYCLES  = 250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 12;

    // One decoded code point as it should appear on the output channel.
    typedef struct packed {
        logic [20:0] cp;
        logic        bad;
        logic        cut;
        logic        ends_string;
    } cp_beat_t;

    // Tracks the open UTF-8 sequence and the code points still owed by the block.
    class codepoint_tracker;
        logic [7:0] lead_byte = 8'h00;
        logic [2:0] open_len  = LEN_NONE;
        logic [7:0] followers [3];
        int         held = 0;
        cp_beat_t   expected_cps [$];
        int         mismatches   = 0;
        int         checked      = 0;
        int         replacements = 0;
        int         cuts         = 0;

        function logic [2:0] length_of(logic [7:0] c);
            if (c < 8'h80) return LEN_ONE;
            if (c < 8'hC0) return LEN_NONE;
            if (c < LEAD_E0) return LEN_TWO;
            if (c < LEAD_F0) return LEN_THREE;
            if (c <= LEAD_F4) return LEN_FOUR;
            return LEN_NONE;
        endfunction

        function bit is_cont(logic [7:0] c);
            return (c & 8'hC0) == 8'h80;
        endfunction

        // Checks a full window and assembles the scalar it carries.
        function bit window_scalar(output logic [20:0] cp);
            logic [7:0]  c;
            logic [7:0]  b1;
            logic [7:0]  b2;
            logic [7:0]  b3;
            logic [20:0] v;
            c  = lead_byte;
            b1 = followers[0];
            cp = REPL_CHAR;
            if (!is_cont(b1)) return 1'b0;
            if (open_len == LEN_TWO) begin
                if (c < LEAD_MIN_TWO) return 1'b0;
                cp = {10'd0, c[4:0], b1[5:0]};
                return 1'b1;
            end
            b2 = followers[1];
            if (!is_cont(b2)) return 1'b0;
            if (open_len == LEN_THREE) begin
                if ((c == LEAD_E0 && b1 < FOLLOW_MIN_E0) ||
                    (c == LEAD_ED && b1 >= FOLLOW_MIN_E0)) return 1'b0;
                cp = {5'd0, c[3:0], b1[5:0], b2[5:0]};
                return 1'b1;
            end
            b3 = followers[2];
            if (!is_cont(b3)) return 1'b0;
            if ((c == LEAD_F0 && b1 < FOLLOW_MIN_F0) ||
                (c == LEAD_F4 && b1 > FOLLOW_MAX_F4)) return 1'b0;
            v = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
            if (v > MAX_CP) return 1'b0;
            cp = v;
            return 1'b1;
        endfunction

        // Decodes one accepted byte and queues the code points it releases.
        function void take_byte(logic [7:0] b, bit fin);
            logic [7:0]  work [$];
            logic [7:0]  cur;
            logic [20:0] cp;
            logic [2:0]  len;
            cp_beat_t    step_out [$];
            work.insert(work.size(), b);
            while (work.size() > 0) begin
                cur = work.pop_front();
                if (open_len == LEN_NONE) begin
                    len = length_of(cur);
                    if (len == LEN_ONE) begin
                        step_out.insert(step_out.size(),
                                        cp_beat_t'{{13'd0, cur}, 1'b0, 1'b0, 1'b0});
                    end else if (len == LEN_NONE) begin
                        step_out.insert(step_out.size(),
                                        cp_beat_t'{REPL_CHAR, 1'b1, 1'b0, 1'b0});
                    end else begin
                        lead_byte = cur;
                        open_len  = len;
                        held      = 0;
                    end
                end else begin
                    if (held < 3) begin
                        followers[held] = cur;
                        held++;
                    end
                    if (held >= open_len - 1) begin
                        if (window_scalar(cp)) begin
                            step_out.insert(step_out.size(),
                                            cp_beat_t'{cp, 1'b0, 1'b0, 1'b0});
                        end else begin
                            // A refused window restarts decoding at the first follower.
                            step_out.insert(step_out.size(),
                                            cp_beat_t'{REPL_CHAR, 1'b1, 1'b0, 1'b0});
                            for (int i = held - 1; i >= 0; i--)
                                work.push_front(followers[i]);
                        end
                        open_len = LEN_NONE;
                        held     = 0;
                    end
                end
            end
            // The string end closes any open sequence with a cut-short replacement.
            if (fin) begin
                if (open_len != LEN_NONE)
                    step_out.insert(step_out.size(),
                                    cp_beat_t'{REPL_CHAR, 1'b1, 1'b1, 1'b0});
                open_len = LEN_NONE;
                held     = 0;
            end
            while (step_out.size() > MAX_RESULTS)
                step_out.delete(step_out.size() - 1);
            if (fin && step_out.size() > 0)
                step_out[step_out.size() - 1].ends_string = 1'b1;
            foreach (step_out[i])
                expected_cps.insert(expected_cps.size(), step_out[i]);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        // Compares one output beat with the oldest expected code point.
        task check_codepoint(logic [20:0] cp, logic bad, logic cut, logic fin);
            cp_beat_t want;
            if (expected_cps.size() == 0) begin
                report_mismatch($sformatf("code point %h arrived with none expected", cp));
                return;
            end
            want = expected_cps.pop_front();
            checked++;
            if (want.bad) replacements++;
            if (want.cut) cuts++;
            if (cp !== want.cp)
                report_mismatch($sformatf("code_point %h, expected %h", cp, want.cp));
            if (bad !== want.bad)
                report_mismatch($sformatf("malformed %b, expected %b on %h", bad, want.bad,
                                          want.cp));
            if (cut !== want.cut)
                report_mismatch($sformatf("cut_short %b, expected %b on %h", cut, want.cut,
                                          want.cp));
            if (fin !== want.ends_string)
                report_mismatch($sformatf("out_last %b, expected %b on %h", fin,
                                          want.ends_string, want.cp));
        endtask

        function int pending();
            return expected_cps.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        in_valid;
    logic        in_ready;
    logic [20:0] code_point;
    logic        malformed;
    logic        cut_short;
    logic        out_last;
    logic        out_valid;
    logic        out_ready;

    codepoint_tracker trk;
    logic [7:0]       str_bytes [$];
    bit               calm       = 1'b0;
    bit               hold_req   = 1'b0;
    int               holds_done = 0;
    int               bytes_sent = 0;
    int               strings    = 0;

    utf8_to_codepoint_decoder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .malformed  (malformed),
        .cut_short  (cut_short),
        .out_last   (out_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(6, 15);
        return $urandom_range(25, 60);
    endfunction

    // Offers one byte and waits until the block takes it.
    task automatic send_byte(logic [7:0] b, bit fin);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_byte  = b;
        in_last  = fin;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        trk.take_byte(b, fin);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_string();
        foreach (str_bytes[i])
            send_byte(str_bytes[i], i == str_bytes.size() - 1);
        strings++;
        str_bytes.delete();
    endtask

    // Adds one byte at the end of the string under construction.
    task automatic add_byte(logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endtask

    // Appends the UTF-8 encoding of a scalar value.
    task automatic append_scalar(logic [20:0] cp);
        if (cp < 21'h80)
        begin
            add_byte(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
        else
        begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [20:0] multibyte_scalar();
        case ($urandom_range(0, 3))
            0: return 21'($urandom_range(21'h80, 21'h7FF));
            1: return 21'($urandom_range(21'h800, 21'hD7FF));
            2: return 21'($urandom_range(21'hE000, 21'hFFFF));
            default: return 21'($urandom_range(21'h10000, MAX_CP));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // A well-formed character: plain ranges plus the boundary scalars.
    task automatic append_good_char();
        logic [20:0] edges [13];
        edges = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000,
                  REPL_CHAR, 21'hFFFF, 21'h10000, 21'hFFFFF, 21'h100000, MAX_CP};
        case ($urandom_range(0, 5))
            0, 1: append_scalar(21'($urandom_range(0, 21'h7F)));
            2: append_scalar(edges[$urandom_range(0, 12)]);
            default: append_scalar(multibyte_scalar());
        endcase
    endtask

    // A broken unit: stray or impossible bytes, overlong, surrogate, out of
    // range, a corrupted follower or a sequence cut off early.
    task automatic append_bad_unit();
        int start;
        int n;
        start = str_bytes.size();
        case ($urandom_range(0, 9))
            0: add_byte(8'($urandom_range(8'h80, 8'hBF)));
            1: add_byte(8'($urandom_range(8'hF5, 8'hFF)));
            2:
            begin
                add_byte(8'($urandom_range(8'hC0, LEAD_MIN_TWO - 1)));
                add_byte(cont_byte());
            end
            3:
            begin
                add_byte(LEAD_E0);
                add_byte(8'($urandom_range(8'h80, FOLLOW_MIN_E0 - 1)));
                add_byte(cont_byte());
            end
            4:
            begin
                add_byte(LEAD_ED);
                add_byte(8'($urandom_range(FOLLOW_MIN_E0, 8'hBF)));
                add_byte(cont_byte());
            end
            5:
            begin
                add_byte(LEAD_F0);
                add_byte(8'($urandom_range(8'h80, FOLLOW_MIN_F0 - 1)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            6:
            begin
                add_byte(LEAD_F4);
                add_byte(8'($urandom_range(FOLLOW_MAX_F4 + 1, 8'hBF)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            7:
            begin
                append_scalar(multibyte_scalar());
                n = str_bytes.size() - start;
                str_bytes[start + $urandom_range(1, n - 1)] = 8'($urandom_range(0, 255));
            end
            8:
            begin
                append_scalar(multibyte_scalar());
                n = str_bytes.size() - start;
                repeat ($urandom_range(1, n - 1)) str_bytes.delete(str_bytes.size() - 1);
            end
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Receiver: random stalls, and on request one long hold-off.
    initial
    begin : receiver
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 99) < 30)
            begin
                out_ready  = 1'b0;
                stall_left = idle_len() - 1;
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Every output beat is checked against the oldest expected code point.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            trk.check_codepoint(code_point, malformed, cut_short, out_last);
    end

    // Ends the run if neither channel moves a beat for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Stalled for %0d cycles with %0d code points outstanding.", quiet,
                 trk.pending());
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int units;
        trk      = new;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_byte  = 8'h00;
        in_last  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: a one-byte string, then the special cases in one string
        // that ends inside an open sequence.
        str_bytes = '{8'h00};
        send_string();
        str_bytes = '{8'h7F,                          // highest ASCII
                      8'h80,                          // continuation as lead
                      8'hFF,                          // impossible lead
                      8'hC0, 8'h80,                   // overlong two-byte form
                      8'hC2, 8'h80,                   // lowest two-byte scalar
                      8'hEF, 8'hBF, 8'hBD,            // literal replacement char
                      8'hE0, 8'h9F, 8'h80,            // overlong three-byte form
                      8'hF4, 8'h90, 8'h80, 8'h80,     // above the Unicode range
                      8'hF0, 8'h90, 8'h80, 8'h80,     // lowest four-byte scalar
                      8'hE1, 8'h80};                  // string ends mid-sequence
        send_string();

        // Random strings, mostly well formed, with calm and hold-off phases.
        while (bytes_sent < ITEMS)
        begin
            calm = (strings >= 10 && strings < 14);
            if (strings == 6 || strings == 18)
                hold_req = 1'b1;
            units = $urandom_range(1, 8);
            repeat (units)
            begin
                if ($urandom_range(0, 99) < 75)
                    append_good_char();
                else
                    append_bad_unit();
            end
            if ($urandom_range(0, 99) < 20)
            begin
                append_scalar(multibyte_scalar());
                str_bytes.delete(str_bytes.size() - 1);
            end
            send_string();
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        while (trk.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d strings; checked %0d code points, %0d of them",
                 bytes_sent, strings, trk.checked, trk.replacements);
        $display("replacements (%0d cut short), across %0d long receiver hold-offs.",
                 trk.cuts, holds_done);
        if (trk.mismatches == 0 && trk.pending() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
